// File: rtl/core/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the splay stencil stream block.
// ----------------------------------------------------------------------------
package sss_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_GRID_ROWS    = 2'd1;

  localparam int unsigned COMP_W  = 16;  // Q2.14 component
  localparam int unsigned SPLAY_W = 36;  // Q8.28 result
  localparam int unsigned COLS_W  = 11;
  localparam int unsigned ROWS_W  = 16;
  localparam int unsigned MIN_DIM = 3;   // smallest grid extent in either direction

  typedef struct packed {
    logic signed [COMP_W-1:0] x_component;
    logic signed [COMP_W-1:0] y_component;
  } point_t;

  typedef struct packed {
    logic [SPLAY_W-1:0] splay_value;
    logic               last_of_frame;
  } result_t;

  typedef struct packed {
    logic [1:0]        index;
    logic [ROWS_W-1:0] wdata;
  } cfg_wr_t;

  // Per-point control decoded from the raster position
  typedef struct packed {
    logic bank;      // x line store bank (row parity)
    logic has_main;  // point yields the result of the row above
    logic interior;  // that result is a real stencil value
    logic has_last;  // point is in the last row: extra zero result
    logic last_col;  // point closes its row
  } pos_flags_t;

endpackage

// File: rtl/core/sss_stream_if.sv
// ----------------------------------------------------------------------------
// sss_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface sss_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sss_position.sv
// ----------------------------------------------------------------------------
// sss_position
// Config registers, raster position counters and per-point flag decode.
// ----------------------------------------------------------------------------
module sss_position import sss_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned CW          = $clog2(MAX_COLUMNS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  cfg_wr_t       cfg_i,
  input  logic          advance_i,
  output logic [CW-1:0] col_o,
  output logic [CW-1:0] col_next_o,
  output pos_flags_t    flags_o
);

  localparam int unsigned GW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;
  localparam logic [GW-1:0] MaxCols = GW'(MAX_COLUMNS);

  logic [COLS_W-1:0] grid_columns_q;
  logic [ROWS_W-1:0] grid_rows_q;
  logic [CW-1:0]     col_q, col_d;
  logic [ROWS_W-1:0] row_q, row_d;
  logic [GW-1:0]     gc_w, cols_last_w;
  logic [CW-1:0]     cols_last;
  logic [ROWS_W-1:0] rows_last;
  logic              last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= COLS_W'(1024);
      grid_rows_q    <= ROWS_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_i.index)
        CFG_GRID_COLUMNS: grid_columns_q <= cfg_i.wdata[COLS_W-1:0];
        CFG_GRID_ROWS:    grid_rows_q    <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Effective extents: columns clamped to [3, MAX_COLUMNS], rows to at least 3
  always_comb begin
    gc_w = GW'(grid_columns_q);
    if (gc_w < GW'(MIN_DIM)) begin
      cols_last_w = GW'(MIN_DIM - 1);
    end else if (gc_w > MaxCols) begin
      cols_last_w = MaxCols - GW'(1);
    end else begin
      cols_last_w = gc_w - GW'(1);
    end
    cols_last = cols_last_w[CW-1:0];
    rows_last = (grid_rows_q < ROWS_W'(MIN_DIM)) ? ROWS_W'(MIN_DIM - 1)
                                                 : grid_rows_q - ROWS_W'(1);
  end

  assign last_col = (col_q >= cols_last);
  assign last_row = (row_q >= rows_last);

  assign col_o      = col_q;
  assign col_next_o = (col_q == CW'(MAX_COLUMNS - 1)) ? '0 : col_q + CW'(1);

  assign flags_o.bank     = row_q[0];
  assign flags_o.has_main = (row_q != '0);
  assign flags_o.interior = (row_q[ROWS_W-1:1] != '0) && (col_q != '0) && !last_col;
  assign flags_o.has_last = last_row;
  assign flags_o.last_col = last_col;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROWS_W'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: rtl/core/sss_line_store.sv
// ----------------------------------------------------------------------------
// sss_line_store
// Two rows of x (banked by row parity) and one row of y, with a zeroing
// sweep after reset. Reads return the contents before the same-edge write.
// ----------------------------------------------------------------------------
module sss_line_store import sss_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned CW          = $clog2(MAX_COLUMNS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     access_i,   // read at col (y also at col_next), write at col
  input  logic [CW-1:0]            col_i,
  input  logic [CW-1:0]            col_next_i,
  input  logic                     bank_i,
  input  logic signed [COMP_W-1:0] x_wdata_i,
  input  logic signed [COMP_W-1:0] y_wdata_i,
  output logic signed [COMP_W-1:0] x_above_o,
  output logic signed [COMP_W-1:0] y_right_o,
  output logic signed [COMP_W-1:0] y_here_o,
  output logic                     clr_busy_o
);

  logic signed [COMP_W-1:0] x_mem0 [MAX_COLUMNS];
  logic signed [COMP_W-1:0] x_mem1 [MAX_COLUMNS];
  logic signed [COMP_W-1:0] y_mem  [MAX_COLUMNS];

  logic                     clr_busy_q;
  logic [CW-1:0]            clr_addr_q;
  logic [CW-1:0]            wr_addr;
  logic                     wr_x0, wr_x1, wr_y;
  logic signed [COMP_W-1:0] x_wr, y_wr;
  logic signed [COMP_W-1:0] x_above_q, y_right_q, y_here_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + CW'(1);
      if (clr_addr_q == CW'(MAX_COLUMNS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_addr = clr_busy_q ? clr_addr_q : col_i;
    x_wr    = clr_busy_q ? '0 : x_wdata_i;
    y_wr    = clr_busy_q ? '0 : y_wdata_i;
    wr_x0   = clr_busy_q || (access_i && !bank_i);
    wr_x1   = clr_busy_q || (access_i && bank_i);
    wr_y    = clr_busy_q || access_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_x0) x_mem0[wr_addr] <= x_wr;
    if (wr_x1) x_mem1[wr_addr] <= x_wr;
    if (wr_y)  y_mem[wr_addr]  <= y_wr;
  end

  always_ff @(posedge clk_i) begin
    if (access_i) begin
      x_above_q <= bank_i ? x_mem1[col_i] : x_mem0[col_i];
      y_right_q <= y_mem[col_next_i];
    end
  end

  // y at the current column feeds the left-neighbor hold, which starts at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_here_q <= '0;
    end else if (access_i) begin
      y_here_q <= y_mem[col_i];
    end
  end

  assign x_above_o  = x_above_q;
  assign y_right_o  = y_right_q;
  assign y_here_o   = y_here_q;
  assign clr_busy_o = clr_busy_q;

endmodule

// File: rtl/core/sss_splay_calc.sv
// ----------------------------------------------------------------------------
// sss_splay_calc
// Sum of the two squared central differences, exact, in Q8.28.
// ----------------------------------------------------------------------------
module sss_splay_calc import sss_pkg::*; (
  input  logic signed [COMP_W-1:0] x_below_i,
  input  logic signed [COMP_W-1:0] x_above_i,
  input  logic signed [COMP_W-1:0] y_right_i,
  input  logic signed [COMP_W-1:0] y_left_i,
  output logic [SPLAY_W-1:0]       splay_o
);

  logic signed [COMP_W:0]   dx, dy;
  logic        [COMP_W:0]   dx_abs, dy_abs;
  logic        [2*COMP_W-1:0] sq_x, sq_y;
  logic        [2*COMP_W:0]   sum;

  always_comb begin
    dx     = {x_below_i[COMP_W-1], x_below_i} - {x_above_i[COMP_W-1], x_above_i};
    dy     = {y_right_i[COMP_W-1], y_right_i} - {y_left_i[COMP_W-1], y_left_i};
    dx_abs = dx[COMP_W] ? -dx : dx;
    dy_abs = dy[COMP_W] ? -dy : dy;
    // |difference| never exceeds 65535, so the low 16 bits carry it
    sq_x   = dx_abs[COMP_W-1:0] * dx_abs[COMP_W-1:0];
    sq_y   = dy_abs[COMP_W-1:0] * dy_abs[COMP_W-1:0];
    sum    = {1'b0, sq_x} + {1'b0, sq_y};
    splay_o = {{(SPLAY_W - 2*COMP_W - 1){1'b0}}, sum};
  end

endmodule

// File: rtl/core/splay_stencil_stream_top.sv
// ----------------------------------------------------------------------------
// splay_stencil_stream_top
// Streaming 3x3 central-difference splay over a raster-order vector field.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                            transfer when
//  --------  ---  ---------------------------------  ------------------
//  point_i   in   x_component, y_component (Q2.14)   valid & ready
//  result_o  out  splay_value (Q8.28), last_of_frame  valid & ready
//  cfg_i     in   index, wdata                        valid & ready
//
//  One point per cycle sustained while result_o is ready; a point waits in the
//  input stage and its result in the result register. Points of the last row
//  yield two results each, so there the point rate is lower, set by the single
//  result register. After reset the line stores are zeroed, one column per
//  cycle, with point_i.ready low until every column is clear. cfg_i is always ready.
//  Output stalls back up through the result register into the input stage.
//
module splay_stencil_stream_top import sss_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sss_stream_if.sink   point_i,
  sss_stream_if.source result_o,
  sss_stream_if.sink   cfg_i
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS);

  // Position tracking and config
  logic          point_xfer;
  logic [CW-1:0] col, col_next;
  pos_flags_t    flags;
  cfg_wr_t       cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.data;

  sss_position #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .CW          (CW)
  ) u_position (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_i      (cfg_wr),
    .advance_i  (point_xfer),
    .col_o      (col),
    .col_next_o (col_next),
    .flags_o    (flags)
  );

  // Line stores: reads and writes happen on the point transfer edge
  point_t                   pt_in;
  logic signed [COMP_W-1:0] x_above, y_right, y_here;
  logic                     clr_busy;

  assign pt_in = point_i.data;

  sss_line_store #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .CW          (CW)
  ) u_line_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .access_i   (point_xfer),
    .col_i      (col),
    .col_next_i (col_next),
    .bank_i     (flags.bank),
    .x_wdata_i  (pt_in.x_component),
    .y_wdata_i  (pt_in.y_component),
    .x_above_o  (x_above),
    .y_right_o  (y_right),
    .y_here_o   (y_here),
    .clr_busy_o (clr_busy)
  );

  // Input stage: current x, decoded flags, and the left-neighbor y hold.
  // The hold takes the y read of the previous point, i.e. the row above
  // one column to the left.
  logic                     s1_v_q, s1_v_d;
  logic signed [COMP_W-1:0] s1_x_q;
  pos_flags_t               s1_flags_q;
  logic signed [COMP_W-1:0] y_left_q;
  logic                     s1_move, s1_has_res;

  // Result register (slot A) and the pending zero result of a last-row point (slot B)
  result_t out_q, out_d;
  logic    out_v_q, out_v_d;
  logic    b_v_q, b_v_d;
  logic    b_last_q, b_last_d;
  logic    a_free;

  logic [SPLAY_W-1:0] splay;

  sss_splay_calc u_calc (
    .x_below_i (s1_x_q),
    .x_above_i (x_above),
    .y_right_i (y_right),
    .y_left_i  (y_left_q),
    .splay_o   (splay)
  );

  assign a_free     = !out_v_q || result_o.ready;
  assign s1_has_res = s1_flags_q.has_main || s1_flags_q.has_last;
  assign s1_move    = s1_v_q && (!s1_has_res || (a_free && !b_v_q));

  assign point_i.ready = !clr_busy && (!s1_v_q || s1_move);
  assign point_xfer    = point_i.valid && point_i.ready;

  assign s1_v_d = point_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_flags_q <= '0;
      y_left_q   <= '0;
    end else begin
      s1_v_q <= s1_v_d;
      if (point_xfer) begin
        s1_flags_q <= flags;
        y_left_q   <= y_here;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (point_xfer) begin
      s1_x_q <= pt_in.x_component;
    end
  end

  // Output slots
  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q && !result_o.ready;
    b_v_d    = b_v_q;
    b_last_d = b_last_q;
    if (s1_move && s1_has_res) begin
      out_v_d = 1'b1;
      if (s1_flags_q.has_main) begin
        out_d.splay_value   = s1_flags_q.interior ? splay : '0;
        out_d.last_of_frame = 1'b0;
        b_v_d               = s1_flags_q.has_last;
        b_last_d            = s1_flags_q.last_col;
      end else begin
        out_d.splay_value   = '0;
        out_d.last_of_frame = s1_flags_q.last_col;
      end
    end else if (a_free && b_v_q) begin
      out_v_d             = 1'b1;
      out_d.splay_value   = '0;
      out_d.last_of_frame = b_last_q;
      b_v_d               = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      b_v_q    <= 1'b0;
      b_last_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      b_v_q    <= b_v_d;
      b_last_q <= b_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_o.valid = out_v_q;
  assign result_o.data  = out_q;

  // Checks
  a_pending_behind_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni) b_v_q |-> out_v_q
  ) else $error("pending zero result without a result in the output register");

  a_no_point_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_busy |-> !point_i.ready
  ) else $error("point accepted during line store clearing");

  a_last_row_has_main: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (s1_v_q && s1_flags_q.has_last) |-> s1_flags_q.has_main
  ) else $error("last-row point without a result for the row above");

  a_two_results_queue: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (s1_move && s1_flags_q.has_main && s1_flags_q.has_last) |=> (b_v_q && out_v_q)
  ) else $error("last-row point did not queue its second result");

endmodule
